// ----- hw/rtl/pehm_pkg.sv -----
// shared types and constants for the profile extremum height mode unit
`default_nettype none

package pehm_pkg;

	localparam int unsigned H_W = 10;
	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_PTR_W = 2;
	localparam int unsigned Q_CNT_W = 3;

	typedef enum logic [1:0] {
		DIR_FLAT = 2'd0,
		DIR_RISE = 2'd1,
		DIR_FALL = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_BUMP = 2'd1,
		OP_SET2 = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		BK_INIT  = 3'd0,
		BK_RUN   = 3'd1,
		BK_DRAIN = 3'd2,
		BK_SCAN  = 3'd3,
		BK_DONE  = 3'd4
	} bk_state_t;

	typedef struct packed {
		op_t            op;
		logic [H_W-1:0] height;
		logic           last;
		logic           mode;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pehm_front.sv -----
// front end: tracks slope of the profile and turns each turning point and each last sample into a histogram command
`default_nettype none

module pehm_front #(
	parameter int unsigned HEIGHT = 1024
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       accept,
	input  wire logic                       mode,
	input  wire logic [pehm_pkg::H_W-1:0]   sample_height,
	input  wire logic                       last_sample,
	output pehm_pkg::cmd_t                  cmd,
	output logic                            push
);
	import pehm_pkg::*;

	logic [H_W-1:0] prev_q;
	dir_t           dir_q;
	logic [1:0]     seen_q;
	dir_t           dir_d;
	op_t            op_d;
	logic           in_range;

	assign in_range = (32'(prev_q) < 32'(HEIGHT));

	always_comb begin
		dir_d = dir_q;
		op_d  = OP_NONE;
		if (seen_q == 2'd1) begin
			if (sample_height > prev_q) begin
				dir_d = DIR_RISE;
			end else if (sample_height < prev_q) begin
				dir_d = DIR_FALL;
			end else begin
				dir_d = DIR_FLAT;
				if (in_range) begin
					op_d = OP_SET2;
				end
			end
		end else if (seen_q >= 2'd2) begin
			if (sample_height > prev_q) begin
				if (mode && dir_q != DIR_RISE && in_range) begin
					op_d = OP_BUMP;
				end
				dir_d = DIR_RISE;
			end else if (sample_height < prev_q) begin
				if (!mode && dir_q != DIR_FALL && in_range) begin
					op_d = OP_BUMP;
				end
				dir_d = DIR_FALL;
			end else begin
				dir_d = DIR_FLAT;
			end
		end
	end

	assign cmd.op     = op_d;
	assign cmd.height = prev_q;
	assign cmd.last   = last_sample;
	assign cmd.mode   = mode;
	assign push       = accept && (op_d != OP_NONE || last_sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			dir_q  <= DIR_FLAT;
			seen_q <= 2'd0;
		end else if (accept) begin
			if (last_sample) begin
				prev_q <= '0;
				dir_q  <= DIR_FLAT;
				seen_q <= 2'd0;
			end else begin
				prev_q <= sample_height;
				dir_q  <= dir_d;
				if (seen_q < 2'd2) begin
					seen_q <= seen_q + 2'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/pehm_queue.sv -----
// short command queue between front and back end
`default_nettype none

module pehm_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire pehm_pkg::cmd_t push_cmd,
	input  wire logic           pop,
	output pehm_pkg::cmd_t      head,
	output pehm_pkg::q_status_t status
);
	import pehm_pkg::*;

	cmd_t               entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;

	assign head         = entry_q[rd_ptr_q];
	assign status.full  = (count_q == Q_CNT_W'(Q_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/pehm_back.sv -----
// back end: histogram memory, read-modify-write of bins, end-of-profile scan and clear
`default_nettype none

module pehm_back #(
	parameter int unsigned HEIGHT    = 1024,
	parameter int unsigned BIN_WIDTH = 12
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire pehm_pkg::cmd_t           head,
	input  wire logic                     q_empty,
	output logic                          pop,
	output logic                          init_busy,
	output logic                          done,
	output logic [pehm_pkg::H_W-1:0]      edge_position
);
	import pehm_pkg::*;

	localparam int unsigned AW = (HEIGHT > 1) ? $clog2(HEIGHT) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(HEIGHT - 1);
	localparam logic [BIN_WIDTH-1:0] BIN_MAX = {BIN_WIDTH{1'b1}};
	localparam logic [BIN_WIDTH-1:0] BIN_TWO = BIN_WIDTH'(2);

	logic [BIN_WIDTH-1:0] mem [HEIGHT];

	bk_state_t            state_q;
	bk_state_t            state_d;
	op_t                  op_s1;
	logic [AW-1:0]        addr_s1;
	logic [BIN_WIDTH-1:0] rd_data_s1;
	logic                 wr_vld_q;
	logic [AW-1:0]        wr_addr_q;
	logic [BIN_WIDTH-1:0] wr_data_q;
	logic [AW-1:0]        scan_addr_q;
	logic                 scan_mode_q;
	logic                 cmp_vld_q;
	logic [AW-1:0]        cmp_addr_q;
	logic [BIN_WIDTH-1:0] best_q;
	logic [AW-1:0]        pos_q;
	logic                 done_q;
	logic [H_W-1:0]       edge_position_q;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [BIN_WIDTH-1:0] mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic                 scan_issue;
	logic [BIN_WIDTH-1:0] old_val;
	logic [BIN_WIDTH-1:0] new_val;
	logic [AW-1:0]        scan_end;
	logic                 better;
	logic [AW-1:0]        final_pos;

	assign old_val   = (wr_vld_q && wr_addr_q == addr_s1) ? wr_data_q : rd_data_s1;
	assign new_val   = (op_s1 == OP_SET2) ? BIN_TWO :
	                   ((old_val == BIN_MAX) ? old_val : old_val + BIN_WIDTH'(1));
	assign scan_end  = scan_mode_q ? LAST_ADDR : '0;
	assign better    = cmp_vld_q && (rd_data_s1 > best_q);
	assign final_pos = better ? cmp_addr_q : pos_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_INIT: begin
				if (scan_addr_q == LAST_ADDR) begin
					state_d = BK_RUN;
				end
			end
			BK_RUN: begin
				if (pop && head.last) begin
					state_d = BK_DRAIN;
				end
			end
			BK_DRAIN: state_d = BK_SCAN;
			BK_SCAN: begin
				if (scan_addr_q == scan_end) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: state_d = BK_RUN;
			default: state_d = BK_INIT;
		endcase
	end

	// outputs
	always_comb begin
		pop        = 1'b0;
		scan_issue = 1'b0;
		init_busy  = 1'b0;
		mem_we     = (op_s1 != OP_NONE);
		mem_waddr  = addr_s1;
		mem_wdata  = new_val;
		mem_raddr  = scan_addr_q;
		unique case (state_q)
			BK_INIT: begin
				init_busy = 1'b1;
				mem_we    = 1'b1;
				mem_waddr = scan_addr_q;
				mem_wdata = '0;
			end
			BK_RUN: begin
				pop = !q_empty;
				if (!q_empty) begin
					mem_raddr = AW'(head.height);
				end
			end
			BK_DRAIN: begin
			end
			BK_SCAN: begin
				scan_issue = 1'b1;
				mem_we     = 1'b1;
				mem_waddr  = scan_addr_q;
				mem_wdata  = '0;
			end
			BK_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// histogram store, read returns the value before a same-cycle write
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		addr_s1   <= AW'(head.height);
		wr_addr_q <= mem_waddr;
		wr_data_q <= mem_wdata;
		cmp_addr_q <= scan_addr_q;
		if (pop && head.last) begin
			scan_mode_q <= head.mode;
		end
		if (state_q == BK_DRAIN) begin
			best_q <= '0;
			pos_q  <= '0;
		end else if (better) begin
			best_q <= rd_data_s1;
			pos_q  <= cmp_addr_q;
		end
		if (state_q == BK_DONE) begin
			edge_position_q <= H_W'(final_pos);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_INIT;
			op_s1       <= OP_NONE;
			wr_vld_q    <= 1'b0;
			cmp_vld_q   <= 1'b0;
			done_q      <= 1'b0;
			scan_addr_q <= '0;
		end else begin
			state_q   <= state_d;
			op_s1     <= pop ? head.op : OP_NONE;
			wr_vld_q  <= mem_we;
			cmp_vld_q <= scan_issue && !(!scan_mode_q && scan_addr_q == '0);
			done_q    <= (state_q == BK_DONE);
			unique case (state_q)
				BK_INIT: begin
					scan_addr_q <= (scan_addr_q == LAST_ADDR) ? '0 : scan_addr_q + AW'(1);
				end
				BK_DRAIN: begin
					scan_addr_q <= scan_mode_q ? '0 : LAST_ADDR;
				end
				BK_SCAN: begin
					scan_addr_q <= scan_mode_q ? scan_addr_q + AW'(1) : scan_addr_q - AW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	assign done          = done_q;
	assign edge_position = edge_position_q;

endmodule

`default_nettype wire

// ----- hw/rtl/profile_extremum_height_mode_unit.sv -----
// top level: mode register, front end, command queue and histogram back end
// a request is taken each cycle while the four-entry command queue has room and no clearing pass runs
// the last sample of a profile starts a scan of all HEIGHT bins once that command leaves
// the queue; done is raised after the scan, and the scan clears each bin it reads
// after reset a clearing pass over all HEIGHT bins runs with busy high
// the result is held on edge_position for the single cycle that done is high
`default_nettype none

module profile_extremum_height_mode_unit #(
	parameter int unsigned HEIGHT    = 1024,
	parameter int unsigned BIN_WIDTH = 12
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     extremum_mode_we,
	input  wire logic                     extremum_mode,
	input  wire logic                     start,
	output logic                          busy,
	input  wire logic [pehm_pkg::H_W-1:0] sample_height,
	input  wire logic                     last_sample,
	output logic                          done,
	output logic [pehm_pkg::H_W-1:0]      edge_position
);
	import pehm_pkg::*;

	logic      mode_q;
	logic      accept;
	logic      push;
	logic      pop;
	logic      init_busy;
	cmd_t      push_cmd;
	cmd_t      head;
	q_status_t q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (extremum_mode_we) begin
			mode_q <= extremum_mode;
		end
	end

	assign busy   = init_busy || q_status.full;
	assign accept = start && !busy;

	pehm_front #(
		.HEIGHT(HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.mode         (mode_q),
		.sample_height(sample_height),
		.last_sample  (last_sample),
		.cmd          (push_cmd),
		.push         (push)
	);

	pehm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.status  (q_status)
	);

	pehm_back #(
		.HEIGHT   (HEIGHT),
		.BIN_WIDTH(BIN_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_empty      (q_status.empty),
		.pop          (pop),
		.init_busy    (init_busy),
		.done         (done),
		.edge_position(edge_position)
	);

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	a_no_done_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !done)
		else $error("result during clearing pass");

	a_last_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_sample) |=> !q_status.empty)
		else $error("end of profile request not queued");

endmodule

`default_nettype wire

// ----- tb/sv/pehm_edge_checker.sv -----
// checker: watches the request, config and result channels, predicts each edge height and compares
module pehm_edge_checker #(
	parameter int unsigned HEIGHT    = 1024,
	parameter int unsigned BIN_WIDTH = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         extremum_mode_we,
	input  logic                         extremum_mode,
	input  logic                         start,
	input  logic                         busy,
	input  logic [pehm_pkg::H_W-1:0]     sample_height,
	input  logic                         last_sample,
	input  logic                         done,
	input  logic [pehm_pkg::H_W-1:0]     edge_position,
	output int unsigned                  errors,
	output int unsigned                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import pehm_pkg::*;

	localparam logic [BIN_WIDTH-1:0] BIN_MAX    = '1;
	localparam logic [BIN_WIDTH-1:0] PAIR_COUNT =
		(BIN_WIDTH'(2) <= BIN_MAX) ? BIN_WIDTH'(2) : BIN_MAX;

	logic                 mode_q;
	logic [H_W-1:0]       prev_h;
	dir_t                 trend;
	logic [1:0]           seen;
	logic [BIN_WIDTH-1:0] turn_bins [HEIGHT];
	logic [H_W-1:0]       predicted_edges [$];

	task automatic report_mismatch(input string what, input logic [H_W-1:0] got,
			input logic [H_W-1:0] want);
		$display("%0t ns: %s: edge_position got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	task automatic clear_profile();
		prev_h = '0;
		trend = DIR_FLAT;
		seen = 2'd0;
		for (int y = 0; y < HEIGHT; y++)
			turn_bins[y] = '0;
	endtask

	task automatic bump_bin(input logic [H_W-1:0] h);
		if (h < HEIGHT && turn_bins[h] != BIN_MAX)
			turn_bins[h] = turn_bins[h] + 1'b1;
	endtask

	function automatic logic [H_W-1:0] busiest_height();
		logic [BIN_WIDTH-1:0] best;
		int unsigned pos;
		best = '0;
		pos = 0;
		if (mode_q == 1'b0) begin
			for (int y = HEIGHT - 1; y > 0; y--)
				if (turn_bins[y] > best) begin
					best = turn_bins[y];
					pos = y;
				end
		end else begin
			for (int y = 0; y < HEIGHT; y++)
				if (turn_bins[y] > best) begin
					best = turn_bins[y];
					pos = y;
				end
		end
		return pos[H_W-1:0];
	endfunction

	task automatic take_sample(input logic [H_W-1:0] h, input logic fin);
		if (seen == 2'd1) begin
			if (h > prev_h)
				trend = DIR_RISE;
			else if (h < prev_h)
				trend = DIR_FALL;
			else begin
				trend = DIR_FLAT;
				if (prev_h < HEIGHT)
					turn_bins[prev_h] = PAIR_COUNT;
			end
		end else if (seen == 2'd2) begin
			if (h > prev_h) begin
				if (mode_q == 1'b1 && trend != DIR_RISE)
					bump_bin(prev_h);
				trend = DIR_RISE;
			end else if (h < prev_h) begin
				if (mode_q == 1'b0 && trend != DIR_FALL)
					bump_bin(prev_h);
				trend = DIR_FALL;
			end else begin
				trend = DIR_FLAT;
			end
		end
		prev_h = h;
		if (seen != 2'd2)
			seen = seen + 2'd1;
		if (fin) begin
			predicted_edges.insert(predicted_edges.size(), busiest_height());
			clear_profile();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [H_W-1:0] want;
		if (!arst_n) begin
			mode_q = 1'b0;
			clear_profile();
			predicted_edges.delete();
			errors = 0;
		end else begin
			if (done) begin
				if (predicted_edges.size() == 0) begin
					report_mismatch("result with no request pending", edge_position, '0);
				end else begin
					want = predicted_edges.pop_front();
					if (edge_position !== want)
						report_mismatch("wrong edge height", edge_position, want);
				end
			end
			if (extremum_mode_we)
				mode_q = extremum_mode;
			if (start && !busy)
				take_sample(sample_height, last_sample);
		end
		pending = predicted_edges.size();
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench top: clock, reset, request and mode stimulus, and the final verdict
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pehm_pkg::*;

	localparam int unsigned HEIGHT     = 1024;
	localparam int unsigned BIN_WIDTH  = 12;
	localparam int unsigned SETTLE     = HEIGHT + 8;
	localparam int unsigned LIMIT      = 5000000;
	localparam int unsigned RANDOM_REQ = 480;
	localparam int unsigned SAT_ROUNDS = 25;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic extremum_mode_we = 1'b0;
	logic extremum_mode = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [H_W-1:0] sample_height = '0;
	logic last_sample = 1'b0;
	logic done;
	logic [H_W-1:0] edge_position;
	int unsigned errors;
	int unsigned pending;
	int unsigned cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	profile_extremum_height_mode_unit #(
		.HEIGHT(HEIGHT),
		.BIN_WIDTH(BIN_WIDTH)
	) u_dut (
		.clk, .arst_n, .extremum_mode_we, .extremum_mode, .start, .busy,
		.sample_height, .last_sample, .done, .edge_position
	);

	pehm_edge_checker #(
		.HEIGHT(HEIGHT),
		.BIN_WIDTH(BIN_WIDTH)
	) u_checker (
		.clk, .arst_n, .extremum_mode_we, .extremum_mode, .start, .busy,
		.sample_height, .last_sample, .done, .edge_position, .errors, .pending
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("profile_extremum_height_mode_unit regression: fail");
			$finish;
		end
	end

	task automatic drive_sample(input logic [H_W-1:0] h, input logic fin);
		start <= 1'b1;
		sample_height <= h;
		last_sample <= fin;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic random_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r >= 92)
			pause($urandom_range(10, 50));
		else if (r >= 60)
			pause($urandom_range(1, 3));
	endtask

	// drain: every predicted edge has come back and the queue is empty
	task automatic settle();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		settle();
		extremum_mode_we <= 1'b1;
		extremum_mode <= m;
		@(posedge clk);
		extremum_mode_we <= 1'b0;
	endtask

	initial begin
		int unsigned sent;
		int unsigned len;
		int unsigned style;
		int unsigned base;
		bit burst;
		logic [H_W-1:0] h;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// maxima mode
		set_mode(1'b0);
		drive_sample(10'd1023, 1'b1);
		drive_sample(10'd0, 1'b0);
		drive_sample(10'd1023, 1'b0);
		drive_sample(10'd0, 1'b0);
		drive_sample(10'd8, 1'b0);
		drive_sample(10'd3, 1'b1);
		drive_sample(10'd7, 1'b0);
		drive_sample(10'd7, 1'b0);
		drive_sample(10'd9, 1'b0);
		drive_sample(10'd4, 1'b1);
		drive_sample(10'd0, 1'b0);
		drive_sample(10'd0, 1'b1);
		drive_sample(10'd5, 1'b0);
		drive_sample(10'd8, 1'b0);
		drive_sample(10'd8, 1'b0);
		drive_sample(10'd2, 1'b1);

		// minima mode, then a mode switch in the middle of a profile
		set_mode(1'b1);
		drive_sample(10'd10, 1'b0);
		drive_sample(10'd4, 1'b0);
		drive_sample(10'd10, 1'b0);
		drive_sample(10'd9, 1'b0);
		drive_sample(10'd10, 1'b1);
		drive_sample(10'd20, 1'b0);
		drive_sample(10'd30, 1'b0);
		drive_sample(10'd20, 1'b0);
		set_mode(1'b0);
		drive_sample(10'd40, 1'b0);
		drive_sample(10'd35, 1'b1);

		// two busy bins, the lower one counted once more
		drive_sample(10'd600, 1'b0);
		drive_sample(10'd100, 1'b0);
		repeat (SAT_ROUNDS) begin
			drive_sample(10'd700, 1'b0);
			drive_sample(10'd100, 1'b0);
			drive_sample(10'd600, 1'b0);
			drive_sample(10'd100, 1'b0);
		end
		drive_sample(10'd600, 1'b0);
		drive_sample(10'd100, 1'b1);

		sent = 0;
		while (sent < RANDOM_REQ) begin
			if ($urandom_range(0, 7) == 0)
				set_mode(1'($urandom_range(0, 1)));
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
			style = $urandom_range(0, 3);
			burst = ($urandom_range(0, 3) == 0);
			base = $urandom_range(0, 1020);
			for (int i = 0; i < len; i++) begin
				case (style)
					0: h = H_W'($urandom_range(0, 1023));
					1: h = H_W'(base + $urandom_range(0, 3));
					2: h = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
					default: h = H_W'($urandom_range(0, 7));
				endcase
				drive_sample(h, i == len - 1);
				sent++;
				if (!burst)
					random_gap();
			end
		end

		settle();
		if (errors == 0 && pending == 0)
			$display("profile_extremum_height_mode_unit regression: pass");
		else
			$display("profile_extremum_height_mode_unit regression: fail");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/pehm_pkg.sv
hw/rtl/pehm_front.sv
hw/rtl/pehm_queue.sv
hw/rtl/pehm_back.sv
hw/rtl/profile_extremum_height_mode_unit.sv
tb/sv/pehm_edge_checker.sv
tb/sv/tb_top.sv
